>>> design/rmth_pkg.sv
package rmth_pkg;

  localparam int HALF_DEPTH_DEF = 512;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_TAKE   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_MEDIAN = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [31:0]  value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]  median;
    logic [1:0]          status;
  } out_word_t;

  typedef enum logic [1:0] {KEY_IN, KEY_T, KEY_RD} key_src_t;
  typedef enum logic [1:0] {RA_PARENT, RA_LAST, RA_CHILD1, RA_CHILD2} raddr_sel_t;
  typedef enum logic [1:0] {WS_KEY, WS_RD, WS_BEST} wsrc_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_PARENT, IDX_BEST, IDX_ZERO} idx_src_t;
  typedef enum logic [1:0] {BEST_HOLD, BEST_C1, BEST_C2} best_sel_t;

  typedef struct packed {
    logic        cap_in;
    logic        sel;
    logic        key_ld;
    key_src_t    key_src;
    logic        push_init;
    logic        pop_init;
    logic        rd_en;
    raddr_sel_t  raddr;
    logic        wr_en;
    wsrc_t       wsrc;
    idx_src_t    idx_src;
    best_sel_t   best_sel;
    logic        clear;
    logic        res_ld;
    logic [1:0]  res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        full;
    logic        empty;
    logic        take_upper;
    logic        ins_rot;
    logic        ins_heap;
    logic        idx_zero;
    logic        key_ahead;
    logic        pop_last;
    logic        has_c1;
    logic        has_c2;
    logic        best_ahead;
    logic        out_free;
  } dp_stat_t;

endpackage

>>> design/running_median_two_heaps_unit.sv
// Channel  Ports                           Word         Direction
// in       in_valid, in_stall, in_word     in_word_t    command into block
// out      out_valid, out_stall, out_word  out_word_t   one result per command
//
// Work per command: a take is one pop, whose sift reads two children per level
// through the single heap read port; an insert is one push sift, or, when a top
// has to cross over, a pop of one top and then two push sifts. Clear, full and
// empty answers go straight to the result.
// Reset clears both counts; heap storage is left as is.
// A finished word waits in the output register while the next command is taken.
module running_median_two_heaps_unit #(
  parameter int HALF_DEPTH = rmth_pkg::HALF_DEPTH_DEF,
  parameter int VALUE_BITS = rmth_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmth_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rmth_pkg::out_word_t out_word
);
  import rmth_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: steps each command through pops and pushes on the two heaps
  rmth_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap RAMs, counts, top shadows, sift registers and the output register
  rmth_dpath #(
    .HALF_DEPTH (HALF_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

  // a taken word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after taking a word");

  // no heap traffic while waiting for a command
  a_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cmd.wr_en && !cmd.rd_en && !cmd.push_init && !cmd.pop_init)
    else $error("heap access while idle");

  // a loaded result shows up on the output
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |=> out_valid)
    else $error("result loaded but not presented");

endmodule

>>> design/rmth_ctrl.sv
module rmth_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmth_pkg::dp_stat_t stat,
  output rmth_pkg::dp_cmd_t  cmd
);
  import rmth_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP,
    S_PU_INIT, S_PU_CHK, S_PU_CMP, S_PU_WR,
    S_PO_INIT, S_PO_KEY, S_PO_CHK, S_PO_C1, S_PO_C2, S_PO_CMP, S_PO_WR,
    S_RES
  } state_t;

  typedef enum logic [1:0] {PH_TAKE, PH_ROT1, PH_ROT2, PH_LAST} phase_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       sel_r, sel_nxt;
  logic       rot_r, rot_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic       pop_done, push_done;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    sel_nxt    = sel_r;
    rot_nxt    = rot_r;
    res_st_nxt = res_st_r;
    pop_done   = 1'b0;
    push_done  = 1'b0;
    cmd        = '0;
    cmd.sel    = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.kind)
          KIND_INSERT: begin
            if (stat.full) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_RES;
            end else begin
              sel_nxt   = stat.ins_heap;
              rot_nxt   = stat.ins_heap;
              phase_nxt = stat.ins_rot ? PH_ROT1 : PH_LAST;
              state_nxt = stat.ins_rot ? S_PO_INIT : S_PU_INIT;
            end
          end
          KIND_TAKE: begin
            if (stat.empty) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_RES;
            end else begin
              sel_nxt   = stat.take_upper;
              phase_nxt = PH_TAKE;
              state_nxt = S_PO_INIT;
            end
          end
          KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            res_st_nxt = ST_DONE;
            state_nxt  = S_RES;
          end
          default: begin
            res_st_nxt = ST_DONE;
            state_nxt  = S_RES;
          end
        endcase
      end
      S_PU_INIT: begin
        cmd.key_ld    = 1'b1;
        cmd.key_src   = (phase_r == PH_ROT2) ? KEY_T : KEY_IN;
        cmd.push_init = 1'b1;
        state_nxt     = S_PU_CHK;
      end
      S_PU_CHK: begin
        if (stat.idx_zero) begin
          state_nxt = S_PU_WR;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.raddr = RA_PARENT;
          state_nxt = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (stat.key_ahead) begin
          cmd.wr_en   = 1'b1;
          cmd.wsrc    = WS_RD;
          cmd.idx_src = IDX_PARENT;
          state_nxt   = S_PU_CHK;
        end else begin
          state_nxt = S_PU_WR;
        end
      end
      S_PU_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc  = WS_KEY;
        push_done = 1'b1;
      end
      S_PO_INIT: begin
        cmd.pop_init = 1'b1;
        if (stat.pop_last) begin
          pop_done = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.raddr = RA_LAST;
          state_nxt = S_PO_KEY;
        end
      end
      S_PO_KEY: begin
        cmd.key_ld  = 1'b1;
        cmd.key_src = KEY_RD;
        cmd.idx_src = IDX_ZERO;
        state_nxt   = S_PO_CHK;
      end
      S_PO_CHK: begin
        if (stat.has_c1) begin
          cmd.rd_en = 1'b1;
          cmd.raddr = RA_CHILD1;
          state_nxt = S_PO_C1;
        end else begin
          state_nxt = S_PO_WR;
        end
      end
      S_PO_C1: begin
        cmd.best_sel = BEST_C1;
        if (stat.has_c2) begin
          cmd.rd_en = 1'b1;
          cmd.raddr = RA_CHILD2;
          state_nxt = S_PO_C2;
        end else begin
          state_nxt = S_PO_CMP;
        end
      end
      S_PO_C2: begin
        cmd.best_sel = BEST_C2;
        state_nxt    = S_PO_CMP;
      end
      S_PO_CMP: begin
        if (stat.best_ahead) begin
          cmd.wr_en   = 1'b1;
          cmd.wsrc    = WS_BEST;
          cmd.idx_src = IDX_BEST;
          state_nxt   = S_PO_CHK;
        end else begin
          state_nxt = S_PO_WR;
        end
      end
      S_PO_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc  = WS_KEY;
        pop_done  = 1'b1;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = res_st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // chain the heap operations of one command
    if (pop_done) begin
      if (phase_r == PH_ROT1) begin
        sel_nxt   = ~rot_r;
        phase_nxt = PH_ROT2;
        state_nxt = S_PU_INIT;
      end else begin
        res_st_nxt = ST_MEDIAN;
        state_nxt  = S_RES;
      end
    end
    if (push_done) begin
      if (phase_r == PH_ROT2) begin
        sel_nxt   = rot_r;
        phase_nxt = PH_LAST;
        state_nxt = S_PU_INIT;
      end else begin
        res_st_nxt = ST_DONE;
        state_nxt  = S_RES;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_LAST;
      sel_r    <= HEAP_LOWER;
      rot_r    <= HEAP_LOWER;
      res_st_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      sel_r    <= sel_nxt;
      rot_r    <= rot_nxt;
      res_st_r <= res_st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> design/rmth_dpath.sv
module rmth_dpath #(
  parameter int HALF_DEPTH = rmth_pkg::HALF_DEPTH_DEF,
  parameter int VALUE_BITS = rmth_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmth_pkg::in_word_t  in_word,
  input  logic                out_stall,
  output logic                out_valid,
  output rmth_pkg::out_word_t out_word,
  input  rmth_pkg::dp_cmd_t   cmd,
  output rmth_pkg::dp_stat_t  stat
);
  import rmth_pkg::*;

  localparam int IW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] VSIGN = {1'b1, {(VB-1){1'b0}}};
  localparam logic [CW:0] TOTAL = (CW+1)'(2 * HALF_DEPTH);

  logic [VB-1:0] lmem [HALF_DEPTH];
  logic [VB-1:0] umem [HALF_DEPTH];

  logic [VB-1:0] lrd_r, urd_r;
  logic [CW-1:0] lcnt_r, ucnt_r;
  logic [VB-1:0] ltop_r, utop_r;
  logic [VB-1:0] in_key_r, key_r, t_r, best_r;
  logic [1:0]    kind_r;
  logic [IW-1:0] idx_r, bidx_r;
  logic [CW-1:0] n_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic [VB-1:0] rdata, top_sel, wdata, key_in;
  logic [CW-1:0] cnt_sel;
  logic [IW-1:0] parent, raddr;
  logic [IW:0]   c1;
  logic [IW+1:0] c2;
  logic [CW:0]   total;
  logic          ins_rot, ins_heap;

  function automatic logic ahead(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                 input logic is_min);
    return is_min ? (a < b) : (a > b);
  endfunction

  assign rdata   = cmd.sel ? urd_r  : lrd_r;
  assign top_sel = cmd.sel ? utop_r : ltop_r;
  assign cnt_sel = cmd.sel ? ucnt_r : lcnt_r;
  assign key_in  = VB'(in_word.value) ^ VSIGN;
  assign parent  = (idx_r - 1'b1) >> 1;
  assign c1      = {idx_r, 1'b1};
  assign c2      = {1'b0, c1} + (IW+2)'(1);
  assign total   = {1'b0, lcnt_r} + {1'b0, ucnt_r};

  always_comb begin
    case (cmd.raddr)
      RA_PARENT: raddr = parent;
      RA_LAST:   raddr = IW'(cnt_sel - 1'b1);
      RA_CHILD1: raddr = c1[IW-1:0];
      RA_CHILD2: raddr = c2[IW-1:0];
      default:   raddr = parent;
    endcase
    case (cmd.wsrc)
      WS_RD:   wdata = rdata;
      WS_BEST: wdata = best_r;
      default: wdata = key_r;
    endcase
  end

  // pick where an insert goes, and whether a top has to cross over
  always_comb begin
    ins_rot  = 1'b0;
    ins_heap = HEAP_LOWER;
    if (lcnt_r == '0 && ucnt_r == '0) begin
      ins_heap = HEAP_LOWER;
    end else if (ucnt_r == '0) begin
      if (in_key_r < ltop_r) begin
        ins_rot  = 1'b1;
        ins_heap = HEAP_LOWER;
      end else begin
        ins_heap = HEAP_UPPER;
      end
    end else if (lcnt_r == '0 || ucnt_r > lcnt_r) begin
      if (in_key_r < utop_r) begin
        ins_heap = HEAP_LOWER;
      end else begin
        ins_rot  = 1'b1;
        ins_heap = HEAP_UPPER;
      end
    end else if (lcnt_r == ucnt_r) begin
      ins_heap = (in_key_r < ltop_r) ? HEAP_LOWER : HEAP_UPPER;
    end else begin
      if (in_key_r > ltop_r) begin
        ins_heap = HEAP_UPPER;
      end else begin
        ins_rot  = 1'b1;
        ins_heap = HEAP_LOWER;
      end
    end
  end

  assign stat.ins_rot    = ins_rot;
  assign stat.ins_heap   = ins_heap;
  assign stat.kind       = kind_r;
  assign stat.full       = (total >= TOTAL);
  assign stat.empty      = (lcnt_r == '0) && (ucnt_r == '0);
  assign stat.take_upper = (ucnt_r > lcnt_r);
  assign stat.idx_zero   = (idx_r == '0);
  assign stat.key_ahead  = ahead(key_r, rdata, cmd.sel);
  assign stat.pop_last   = (cnt_sel == CW'(1));
  assign stat.has_c1     = (c1 < n_r);
  assign stat.has_c2     = (c2 < {1'b0, n_r});
  assign stat.best_ahead = ahead(best_r, key_r, cmd.sel);
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.sel == HEAP_LOWER) lmem[idx_r] <= wdata;
    if (cmd.wr_en && cmd.sel == HEAP_UPPER) umem[idx_r] <= wdata;
    if (cmd.rd_en) begin
      lrd_r <= lmem[raddr];
      urd_r <= umem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_key_r <= key_in;
      kind_r   <= in_word.kind;
    end
    if (cmd.key_ld) begin
      case (cmd.key_src)
        KEY_T:   key_r <= t_r;
        KEY_RD:  key_r <= rdata;
        default: key_r <= in_key_r;
      endcase
    end
    if (cmd.push_init) idx_r <= IW'(cnt_sel);
    case (cmd.idx_src)
      IDX_PARENT: idx_r <= parent;
      IDX_BEST:   idx_r <= bidx_r;
      IDX_ZERO:   idx_r <= '0;
      default:    ;
    endcase
    if (cmd.pop_init) begin
      t_r <= top_sel;
      n_r <= cnt_sel - 1'b1;
    end
    case (cmd.best_sel)
      BEST_C1: begin
        best_r <= rdata;
        bidx_r <= c1[IW-1:0];
      end
      BEST_C2: begin
        if (ahead(rdata, best_r, cmd.sel)) begin
          best_r <= rdata;
          bidx_r <= c2[IW-1:0];
        end
      end
      default: ;
    endcase
    if (cmd.wr_en && idx_r == '0) begin
      if (cmd.sel == HEAP_UPPER) utop_r <= wdata;
      else                       ltop_r <= wdata;
    end
    if (cmd.res_ld) begin
      out_word_r.status <= cmd.res_status;
      out_word_r.median <= (cmd.res_status == ST_MEDIAN) ? 32'(t_r ^ VSIGN) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r      <= '0;
      ucnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        lcnt_r <= '0;
        ucnt_r <= '0;
      end else if (cmd.push_init) begin
        if (cmd.sel == HEAP_UPPER) ucnt_r <= ucnt_r + 1'b1;
        else                       lcnt_r <= lcnt_r + 1'b1;
      end else if (cmd.pop_init) begin
        if (cmd.sel == HEAP_UPPER) ucnt_r <= ucnt_r - 1'b1;
        else                       lcnt_r <= lcnt_r - 1'b1;
      end
      if (cmd.res_ld)      out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> tb/running_median_two_heaps_unit_tb.sv
`timescale 1ns / 1ps

module running_median_two_heaps_unit_tb;
  import rmth_pkg::*;

  localparam int HALF_DEPTH  = HALF_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  running_median_two_heaps_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // 4 ns period, high then low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the two heaps; keys carry the sign bit flipped so that
  // unsigned compare gives signed order. Index 0 is the lower (max) heap.
  logic [31:0] heap_keys [2][HALF_DEPTH];
  int unsigned heap_size [2];

  out_word_t results_due [$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        cycles = 0;

  function automatic bit ranks_higher(logic [31:0] a, logic [31:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  function automatic void heap_push(int h, logic [31:0] key);
    int unsigned i;
    int unsigned p;
    logic [31:0] t;
    bit is_max;
    is_max = (h == int'(HEAP_LOWER));
    i = heap_size[h];
    if (i >= HALF_DEPTH) return;
    heap_keys[h][i] = key;
    heap_size[h] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_higher(heap_keys[h][i], heap_keys[h][p], is_max)) break;
      t = heap_keys[h][p];
      heap_keys[h][p] = heap_keys[h][i];
      heap_keys[h][i] = t;
      i = p;
    end
  endfunction

  function automatic logic [31:0] heap_pop(int h);
    int unsigned n;
    int unsigned i;
    int unsigned c;
    logic [31:0] top;
    logic [31:0] t;
    bit is_max;
    is_max = (h == int'(HEAP_LOWER));
    n = heap_size[h];
    i = 0;
    if (n == 0) return '0;
    top = heap_keys[h][0];
    n--;
    heap_keys[h][0] = heap_keys[h][n];
    heap_size[h] = n;
    while (2 * i + 1 < n) begin
      c = 2 * i + 1;
      if (c + 1 < n && ranks_higher(heap_keys[h][c + 1], heap_keys[h][c], is_max)) c++;
      if (!ranks_higher(heap_keys[h][c], heap_keys[h][i], is_max)) break;
      t = heap_keys[h][c];
      heap_keys[h][c] = heap_keys[h][i];
      heap_keys[h][i] = t;
      i = c;
    end
    return top;
  endfunction

  // Place one key, moving a top across where the halves would drift apart.
  function automatic void place_key(logic [31:0] key);
    int lo;
    int hi;
    logic [31:0] t;
    lo = int'(HEAP_LOWER);
    hi = int'(HEAP_UPPER);
    if (heap_size[lo] == 0 && heap_size[hi] == 0) begin
      heap_push(lo, key);
    end else if (heap_size[lo] == 0) begin
      if (key < heap_keys[hi][0]) begin
        heap_push(lo, key);
      end else begin
        t = heap_pop(hi);
        heap_push(lo, t);
        heap_push(hi, key);
      end
    end else if (heap_size[hi] == 0) begin
      if (key < heap_keys[lo][0]) begin
        t = heap_pop(lo);
        heap_push(lo, key);
        heap_push(hi, t);
      end else begin
        heap_push(hi, key);
      end
    end else if (heap_size[lo] == heap_size[hi]) begin
      if (key < heap_keys[lo][0]) heap_push(lo, key);
      else heap_push(hi, key);
    end else if (heap_size[lo] > heap_size[hi]) begin
      if (key > heap_keys[lo][0]) begin
        heap_push(hi, key);
      end else begin
        t = heap_pop(lo);
        heap_push(hi, t);
        heap_push(lo, key);
      end
    end else begin
      if (key < heap_keys[hi][0]) begin
        heap_push(lo, key);
      end else begin
        t = heap_pop(hi);
        heap_push(hi, key);
        heap_push(lo, t);
      end
    end
  endfunction

  function automatic out_word_t median_after(in_word_t w);
    out_word_t r;
    logic [31:0] key;
    int lo;
    int hi;
    lo = int'(HEAP_LOWER);
    hi = int'(HEAP_UPPER);
    r = '0;
    r.status = ST_DONE;
    case (w.kind)
      KIND_INSERT: begin
        if (heap_size[lo] + heap_size[hi] >= 2 * HALF_DEPTH) r.status = ST_FULL;
        else place_key(w.value ^ 32'h8000_0000);
      end
      KIND_TAKE: begin
        if (heap_size[lo] == 0 && heap_size[hi] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          key = (heap_size[hi] > heap_size[lo]) ? heap_pop(hi) : heap_pop(lo);
          r.median = key ^ 32'h8000_0000;
          r.status = ST_MEDIAN;
        end
      end
      KIND_CLEAR: begin
        heap_size[lo] = 0;
        heap_size[hi] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one word: idle at random, hold it until accepted, then predict.
  // Stall only moves at the rising edge, so its level at the falling edge
  // tells whether the coming rising edge takes the word.
  task automatic send_word(logic [1:0] kind, logic signed [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word.kind = kind;
    in_word.value = value;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    results_due.push_back(median_after(in_word));
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid = 1'b0;
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic drain();
    go_idle();
    while (results_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(15)) - 8;
      2: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return {1'($urandom_range(1)), 31'h7fff_ff00 + 31'($urandom_range(255))};
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return KIND_INSERT;
    if (r < 90) return KIND_TAKE;
    if (r < 95) return KIND_CLEAR;
    return KIND_UNUSED;
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_word(KIND_TAKE, 32'sd0);           // take on empty set
    send_word(KIND_UNUSED, 32'sh1234_5678);
    send_word(KIND_INSERT, 32'sh8000_0000);
    send_word(KIND_INSERT, 32'sh7fff_ffff);
    send_word(KIND_INSERT, -32'sd1);
    send_word(KIND_INSERT, 32'sd0);
    send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_TAKE, 32'sd0);
    // equal values: equal halves, then lower half larger
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'sd5);
    send_word(KIND_INSERT, 32'sd3);
    send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_CLEAR, 32'sh5555_aaaa);
    send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_INSERT, 32'sh5555_aaaa);
    send_word(KIND_TAKE, 32'sd0);
    drain();
  endtask

  // Fill storage, push past full, then unload a little and clear.
  task automatic test_full_storage();
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_word(KIND_CLEAR, 32'sd0);
    for (int i = 0; i < 2 * HALF_DEPTH; i++) send_word(KIND_INSERT, pick_value());
    for (int i = 0; i < 3; i++) send_word(KIND_INSERT, pick_value());
    for (int i = 0; i < 8; i++) send_word(KIND_TAKE, 32'sd0);
    send_word(KIND_INSERT, pick_value());
    send_word(KIND_CLEAR, 32'sd0);
    send_word(KIND_TAKE, 32'sd0);
  endtask

  task automatic test_random_mix(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_word(pick_kind(), pick_value());
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h actual %0h", field, want, got);
  endtask

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected word", '0, out_word.median);
      end else begin
        want = results_due.pop_front();
        if (out_word.median !== want.median)
          report_mismatch("median", want.median, out_word.median);
        if (out_word.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_word.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    heap_size[0] = 0;
    heap_size[1] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_full_storage();
    test_random_mix(0, 0, 175);
    test_random_mix(72, 0, 175);
    drain();
    test_random_mix(0, 72, 175);
    test_random_mix(36, 36, 175);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
design/rmth_pkg.sv
design/rmth_ctrl.sv
design/rmth_dpath.sv
design/running_median_two_heaps_unit.sv
tb/running_median_two_heaps_unit_tb.sv
